FILE: rtl/core/xoshiro256ss_random_generator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the xoshiro256** random generator
// Shared property forms; each use sits on a line of its own.
// ----------------------------------------------------------------------------
`ifndef XOSHIRO256SS_RANDOM_GENERATOR_DEFINES_SVH
`define XOSHIRO256SS_RANDOM_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XSR_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XSR_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/xsr_pkg.sv
// ----------------------------------------------------------------------------
// xsr_pkg
// Widths, constants, status types and helpers of the xoshiro256** generator.
// ----------------------------------------------------------------------------
package xsr_pkg;

  localparam int unsigned WORD_W        = 64;
  localparam int unsigned FUNC_W        = 2;
  localparam int unsigned NUM_WORDS     = 4;
  localparam int unsigned WORD_IDX_W    = $clog2(NUM_WORDS);
  // Default multiplier digit width; a power of two from 1 to 32.
  localparam int unsigned MUL_DIGIT_W_DEF = 4;

  // Request codes.
  localparam logic [FUNC_W-1:0] FUNC_SEED  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NEXT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RANGE = 2'd2;

  // Splitmix64 constants.
  localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;
  localparam int unsigned MIX_SHIFT_1 = 30;
  localparam int unsigned MIX_SHIFT_2 = 27;
  localparam int unsigned MIX_SHIFT_3 = 31;

  // Xoshiro256** constants.
  localparam int unsigned XS_SHIFT   = 17;
  localparam int unsigned XS_ROT     = 45;
  localparam int unsigned SCR_ROT    = 7;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  // Status of a multi-cycle arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Rotate left by a constant amount between 1 and WORD_W-1.
  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned amt);
    rotl = (v << amt) | (v >> (WORD_W - amt));
  endfunction

endpackage

FILE: rtl/core/xsr_mul.sv
// ----------------------------------------------------------------------------
// xsr_mul
// Digit-serial multiplier giving the low word of a product, one digit a cycle.
// ----------------------------------------------------------------------------
module xsr_mul #(
  parameter int unsigned DIGIT_W = xsr_pkg::MUL_DIGIT_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [xsr_pkg::WORD_W-1:0] mcand,
  input  logic [xsr_pkg::WORD_W-1:0] mplier,
  output xsr_pkg::unit_stat_t        stat,
  output logic [xsr_pkg::WORD_W-1:0] product
);
  import xsr_pkg::*;

  localparam int unsigned STEPS = WORD_W / DIGIT_W;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [WORD_W-1:0]         mcand_r, mcand_nxt;
  logic [WORD_W-1:0]         mplier_r, mplier_nxt;
  logic [WORD_W-1:0]         acc_r, acc_nxt;
  logic [WORD_W+DIGIT_W-1:0] partial;

  // One digit of the multiplier times the shifted multiplicand.
  assign partial = {{DIGIT_W{1'b0}}, mcand_r} * {{WORD_W{1'b0}}, mplier_r[DIGIT_W-1:0]};

  // Next-state logic for the sequencer and the shift registers.
  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      mcand_nxt  = mcand;
      mplier_nxt = mplier;
      acc_nxt    = '0;
    end else if (busy_r) begin
      acc_nxt    = acc_r + partial[WORD_W-1:0];
      mcand_nxt  = mcand_r << DIGIT_W;
      mplier_nxt = mplier_r >> DIGIT_W;
      cnt_nxt    = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule

FILE: rtl/core/xsr_div.sv
// ----------------------------------------------------------------------------
// xsr_div
// Bit-serial restoring divider that returns the remainder, one bit a cycle.
// ----------------------------------------------------------------------------
module xsr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [xsr_pkg::WORD_W-1:0] dividend,
  input  logic [xsr_pkg::WORD_W-1:0] divisor,
  output xsr_pkg::unit_stat_t        stat,
  output logic [xsr_pkg::WORD_W-1:0] remainder
);
  import xsr_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] dvs_r, dvs_nxt;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;
  logic              fits;

  // Bring down the next dividend bit and subtract the divisor when it fits.
  assign trial = {rem_r, quo_r[WORD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      quo_nxt = quo_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/core/xoshiro256ss_random_generator.sv
// ----------------------------------------------------------------------------
// xoshiro256ss_random_generator
// Xoshiro256** generator with splitmix64 seeding and unbiased range draws.
// ----------------------------------------------------------------------------
// Usage: one request per input transaction (in_valid/in_ready). Func 0 seeds
// the four state words from in_seed_value and returns nothing. Func 1
// returns one raw draw. Func 2 returns a uniform draw in the signed range
// in_range_low..in_range_high; inverted bounds return zero with
// out_bad_bounds set and leave the state alone. Func 3 is dropped.
// A range that spans every value is drawn like a raw draw. A range draw
// runs the bit-serial remainder divider once for the acceptance limit and
// once for the final remainder; a rejected draw is drawn again before the
// remainder. Inverted bounds skip the draw. A seed runs two products per
// state word on the digit-serial multiplier, of digit width MUL_DIGIT_W.
// One request is worked on at a time; in_ready is high only when idle.
// Results sit in an output register, so a new request is accepted while
// the last result still waits; a stalled receiver holds the next result.
// Reset clears the state words to zero, so raw draws return zero until seeded.
// ----------------------------------------------------------------------------
`include "xoshiro256ss_random_generator_defines.svh"

module xoshiro256ss_random_generator #(
  parameter int unsigned MUL_DIGIT_W = xsr_pkg::MUL_DIGIT_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [xsr_pkg::FUNC_W-1:0]        in_func,
  input  logic [xsr_pkg::WORD_W-1:0]        in_seed_value,
  input  logic signed [xsr_pkg::WORD_W-1:0] in_range_low,
  input  logic signed [xsr_pkg::WORD_W-1:0] in_range_high,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [xsr_pkg::WORD_W-1:0]        out_number,
  output logic                              out_bad_bounds
);
  import xsr_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_DECODE    = 11'b000_0000_0010,
    ST_SEED_MIX  = 11'b000_0000_0100,
    ST_SEED_MULA = 11'b000_0000_1000,
    ST_SEED_MULB = 11'b000_0001_0000,
    ST_LIMIT     = 11'b000_0010_0000,
    ST_DRAW      = 11'b000_0100_0000,
    ST_SCRAMBLE  = 11'b000_1000_0000,
    ST_CHECK     = 11'b001_0000_0000,
    ST_REM       = 11'b010_0000_0000,
    ST_EMIT      = 11'b100_0000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [WORD_W-1:0]        gen_word_r [NUM_WORDS];
  logic [WORD_W-1:0]        gen_word_nxt [NUM_WORDS];
  logic [WORD_IDX_W-1:0]    word_idx_r, word_idx_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [FUNC_W-1:0]        func_r, func_nxt;
  logic [WORD_W-1:0]        acc_r, acc_nxt;
  logic signed [WORD_W-1:0] lo_r, lo_nxt;
  logic signed [WORD_W-1:0] hi_r, hi_nxt;
  logic [WORD_W-1:0]        limit_r, limit_nxt;
  logic                     raw_mode_r, raw_mode_nxt;
  logic [WORD_W-1:0]        t_r, t_nxt;
  logic [WORD_W-1:0]        draw_r, draw_nxt;
  logic [WORD_W-1:0]        result_r, result_nxt;
  logic                     bad_r, bad_nxt;
  logic [WORD_W-1:0]        out_number_r, out_number_nxt;
  logic                     out_bad_r, out_bad_nxt;

  logic                     in_fire;
  logic                     out_free;
  logic [WORD_W-1:0]        span;
  logic [WORD_W-1:0]        size;
  logic                     bounds_bad;
  logic [WORD_W-1:0]        acc_step;
  logic [WORD_W-1:0]        rot_t;

  logic                     mul_start;
  logic [WORD_W-1:0]        mul_a;
  logic [WORD_W-1:0]        mul_b;
  unit_stat_t               mul_stat;
  logic [WORD_W-1:0]        mul_prod;

  logic                     div_start;
  logic [WORD_W-1:0]        div_dividend;
  unit_stat_t               div_stat;
  logic [WORD_W-1:0]        div_rem;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Range arithmetic on the held bounds.
  assign bounds_bad = hi_r < lo_r;
  assign span       = $unsigned(hi_r) - $unsigned(lo_r);
  assign size       = span + 1'b1;

  // Splitmix64 counter step and the scrambler rotate.
  assign acc_step = acc_r + GOLDEN_STEP;
  assign rot_t    = rotl(t_r, SCR_ROT);

  // Multiplier operands: first or second mixing product.
  always_comb begin
    mul_b = (state_r == ST_SEED_MIX) ? MIX_MUL_A : MIX_MUL_B;
    if (state_r == ST_SEED_MIX) begin
      mul_a = acc_step ^ (acc_step >> MIX_SHIFT_1);
    end else begin
      mul_a = mul_prod ^ (mul_prod >> MIX_SHIFT_2);
    end
  end

  assign mul_start = (state_r == ST_SEED_MIX) ||
                     ((state_r == ST_SEED_MULA) && mul_stat.done);

  // Divider: acceptance limit at decode, draw remainder after a check.
  assign div_dividend = (state_r == ST_DECODE) ? ALL_ONES : draw_r;

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt      = state_r;
    gen_word_nxt   = gen_word_r;
    word_idx_nxt   = word_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    func_nxt       = func_r;
    acc_nxt        = acc_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    limit_nxt      = limit_r;
    raw_mode_nxt   = raw_mode_r;
    t_nxt          = t_r;
    draw_nxt       = draw_r;
    result_nxt     = result_r;
    bad_nxt        = bad_r;
    out_number_nxt = out_number_r;
    out_bad_nxt    = out_bad_r;
    div_start      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt     = in_func;
          acc_nxt      = in_seed_value;
          lo_nxt       = in_range_low;
          hi_nxt       = in_range_high;
          word_idx_nxt = '0;
          state_nxt    = ST_DECODE;
        end
      end

      ST_DECODE: begin
        case (func_r)
          FUNC_SEED: begin
            state_nxt = ST_SEED_MIX;
          end
          FUNC_NEXT: begin
            raw_mode_nxt = 1'b1;
            state_nxt    = ST_DRAW;
          end
          FUNC_RANGE: begin
            if (bounds_bad) begin
              result_nxt = '0;
              bad_nxt    = 1'b1;
              state_nxt  = ST_EMIT;
            end else if (span == ALL_ONES) begin
              raw_mode_nxt = 1'b1;
              state_nxt    = ST_DRAW;
            end else begin
              raw_mode_nxt = 1'b0;
              div_start    = 1'b1;
              state_nxt    = ST_LIMIT;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      // Seeding: one splitmix64 output per pass, two serial products each.
      ST_SEED_MIX: begin
        acc_nxt   = acc_step;
        state_nxt = ST_SEED_MULA;
      end

      ST_SEED_MULA: begin
        if (mul_stat.done) begin
          state_nxt = ST_SEED_MULB;
        end
      end

      ST_SEED_MULB: begin
        if (mul_stat.done) begin
          gen_word_nxt[word_idx_r] = mul_prod ^ (mul_prod >> MIX_SHIFT_3);
          if (word_idx_r == WORD_IDX_W'(NUM_WORDS - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            word_idx_nxt = word_idx_r + 1'b1;
            state_nxt    = ST_SEED_MIX;
          end
        end
      end

      ST_LIMIT: begin
        if (div_stat.done) begin
          limit_nxt = ALL_ONES - div_rem;
          state_nxt = ST_DRAW;
        end
      end

      // Draw: first scrambler product and the state advance.
      ST_DRAW: begin
        t_nxt           = gen_word_r[1] + {gen_word_r[1][WORD_W-3:0], 2'b00};
        gen_word_nxt[0] = gen_word_r[0] ^ gen_word_r[3] ^ gen_word_r[1];
        gen_word_nxt[1] = gen_word_r[1] ^ gen_word_r[2] ^ gen_word_r[0];
        gen_word_nxt[2] = gen_word_r[2] ^ gen_word_r[0] ^ (gen_word_r[1] << XS_SHIFT);
        gen_word_nxt[3] = rotl(gen_word_r[3] ^ gen_word_r[1], XS_ROT);
        state_nxt       = ST_SCRAMBLE;
      end

      ST_SCRAMBLE: begin
        draw_nxt  = rot_t + {rot_t[WORD_W-4:0], 3'b000};
        state_nxt = ST_CHECK;
      end

      // Rejection test against the acceptance limit.
      ST_CHECK: begin
        if (raw_mode_r) begin
          result_nxt = draw_r;
          bad_nxt    = 1'b0;
          state_nxt  = ST_EMIT;
        end else if ((draw_r == ALL_ONES) || (draw_r > limit_r)) begin
          state_nxt = ST_DRAW;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_REM;
        end
      end

      ST_REM: begin
        if (div_stat.done) begin
          result_nxt = $unsigned(lo_r) + div_rem;
          bad_nxt    = 1'b0;
          state_nxt  = ST_EMIT;
        end
      end

      // Hand the result to the output register once it is free.
      ST_EMIT: begin
        if (out_free) begin
          out_number_nxt = result_r;
          out_bad_nxt    = bad_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers and the generator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      word_idx_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        gen_word_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      word_idx_r  <= word_idx_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_WORDS; i++) begin
        gen_word_r[i] <= gen_word_nxt[i];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    acc_r        <= acc_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    limit_r      <= limit_nxt;
    raw_mode_r   <= raw_mode_nxt;
    t_r          <= t_nxt;
    draw_r       <= draw_nxt;
    result_r     <= result_nxt;
    bad_r        <= bad_nxt;
    out_number_r <= out_number_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  // Digit-serial multiplier for the splitmix64 products.
  xsr_mul #(
    .DIGIT_W (MUL_DIGIT_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  // Bit-serial remainder unit for the range draws.
  xsr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (size),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  assign out_valid      = out_valid_r;
  assign out_number     = out_number_r;
  assign out_bad_bounds = out_bad_r;

  // Assertions.
  `XSR_CHECK_NOW(a_mul_start_idle, mul_start, !mul_stat.busy, "multiplier restarted while busy")
  `XSR_CHECK_NOW(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `XSR_CHECK_NEXT(a_range_in_bounds, (state_r == ST_REM) && div_stat.done, ($signed(result_r) >= lo_r) && ($signed(result_r) <= hi_r), "range draw outside its bounds")
  `XSR_CHECK_NOW(a_bad_bounds_zero, out_valid_r && out_bad_r, out_number_r == '0, "bad bounds result is not zero")

endmodule
